/* hdl/bvpr_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and the check function of the bit-vote packet recovery block.
package bvpr_pkg;

  localparam int unsigned BYTE_W = 8;

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_VOTE    = 2'd1,
    OP_RESOLVE = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_BYTE  = 2'd0,
    STAT_MATCH = 2'd1,
    STAT_FAIL  = 2'd2,
    STAT_FEW   = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_ACCESS
  } state_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PKT_LEN   = 2'd0;
  localparam logic [1:0] CFG_SLOT_OFS  = 2'd1;
  localparam logic [1:0] CFG_EPOCH_OFS = 2'd2;
  localparam logic [1:0] CFG_MIN_VOTES = 2'd3;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [8:0]  CHK_BYTES = 9'd2;

  // Counter memory request from the controller.
  typedef struct packed {
    logic              clear;
    logic              rd_en;
    logic [BYTE_W-1:0] rd_addr;
    logic              wr_en;
    logic [BYTE_W-1:0] wr_addr;
  } mem_req_t;

  // One byte into a CRC-16-CCITT, MSB first.
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* hdl/bvpr_mem.sv */
`timescale 1ns / 1ps
// Counter memory: one row of eight bit counters per byte position, with per-row valid bits.
module bvpr_mem #(
  parameter int unsigned MAX_BYTES    = 256,
  parameter int unsigned COUNTER_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bvpr_pkg::mem_req_t         req_i,
  input  logic [8*COUNTER_BITS-1:0]  wr_data_i,
  output logic [8*COUNTER_BITS-1:0]  rd_data_o
);
  import bvpr_pkg::*;

  localparam int unsigned AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int unsigned DW = 8 * COUNTER_BITS;

  logic [DW-1:0]        mem [MAX_BYTES];
  logic [MAX_BYTES-1:0] valid_q;
  logic [DW-1:0]        rd_data_q;
  logic                 rd_valid_q;

  // A row that was never written since the last clear reads as all counters zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr[AW-1:0]] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr[AW-1:0]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr[AW-1:0]] <= wr_data_i;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr[AW-1:0]];
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

endmodule

/* hdl/bvpr_update.sv */
`timescale 1ns / 1ps
// Saturating update of one row of bit counters and the majority byte of that row.
module bvpr_update #(
  parameter int unsigned COUNTER_BITS = 8
) (
  input  logic [8*COUNTER_BITS-1:0] cnt_i,
  input  logic [7:0]                vote_byte_i,
  output logic [8*COUNTER_BITS-1:0] cnt_o,
  output logic [7:0]                majority_o
);
  import bvpr_pkg::*;

  localparam logic [COUNTER_BITS-1:0] CNT_MAX = {1'b0, {(COUNTER_BITS-1){1'b1}}};
  localparam logic [COUNTER_BITS-1:0] CNT_MIN = {1'b1, {(COUNTER_BITS-1){1'b0}}};

  logic [7:0][COUNTER_BITS-1:0] cnt_in;
  logic [7:0][COUNTER_BITS-1:0] cnt_out;

  assign cnt_in = cnt_i;
  assign cnt_o  = cnt_out;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      cnt_out[k] = cnt_in[k];
      if (vote_byte_i[k]) begin
        if (cnt_in[k] != CNT_MAX) cnt_out[k] = cnt_in[k] + 1'b1;
      end else begin
        if (cnt_in[k] != CNT_MIN) cnt_out[k] = cnt_in[k] - 1'b1;
      end
      // A tie counts as a one, so only a negative counter gives zero.
      majority_o[k] = ~cnt_in[k][COUNTER_BITS-1];
    end
  end

endmodule

/* hdl/bit_vote_packet_recovery.sv */
`timescale 1ns / 1ps
// Top level of the bit-vote packet recovery block: control, check logic and result register.
//
//  Channel  Handshake                 Payload
//  in       in_valid_i / in_stall_o   operation_i, byte_index_i, data_byte_i, last_i
//  out      out_valid_o / out_stall_i voted_byte_o, status_o, copies_voted_o
//  cfg      cfg_we_i                  cfg_index_i, cfg_data_i
//
// A resolve request, and a vote request that changes a counter row, is read from the counter
// memory in S_IDLE and then does the read-modify-write or the vote evaluation in S_ACCESS.
// Clear, no-op and ignored vote requests (beyond the packet or storage, or after recovery) stay in S_IDLE.
// A resolve request waits in S_ACCESS while a previous result is still stalled.
// Reset clears all counters at once through the per-row valid bits; no clearing pass.
module bit_vote_packet_recovery #(
  parameter int unsigned MAX_BYTES    = 256,
  parameter int unsigned COUNTER_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bvpr_pkg::op_e        operation_i,
  input  logic [7:0]           byte_index_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           voted_byte_o,
  output bvpr_pkg::status_e    status_o,
  output logic [7:0]           copies_voted_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [7:0]           cfg_data_i
);
  import bvpr_pkg::*;

  localparam int unsigned DW = 8 * COUNTER_BITS;

  // Configuration
  logic [7:0] pkt_len_q, slot_ofs_q, epoch_ofs_q, min_votes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_len_q   <= 8'd255;
      slot_ofs_q  <= 8'd0;
      epoch_ofs_q <= 8'd0;
      min_votes_q <= 8'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PKT_LEN:   pkt_len_q   <= cfg_data_i;
        CFG_SLOT_OFS:  slot_ofs_q  <= cfg_data_i;
        CFG_EPOCH_OFS: epoch_ofs_q <= cfg_data_i;
        CFG_MIN_VOTES: min_votes_q <= cfg_data_i;
      endcase
    end
  end

  // Request decode
  state_e     state_q, state_d;
  logic       in_acc;
  logic       in_store;
  logic       forced;
  logic       go_access;
  logic       out_free;
  logic       commit_rsv;
  mem_req_t   mem_req;

  logic       recovered_q;
  logic [7:0] copy_cnt_q;
  logic [15:0] crc_q, rx_q;

  op_e        op_q;
  logic [7:0] idx_q, data_q;
  logic       last_q, inr_q, forced_q;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign in_store = ({1'b0, byte_index_i} < 9'(MAX_BYTES));
  assign forced   = (byte_index_i == slot_ofs_q) || (byte_index_i == epoch_ofs_q) ||
                    ({1'b0, byte_index_i} == ({1'b0, epoch_ofs_q} + 9'd1));

  // Only votes that touch a counter row, and all resolves, need the memory.
  always_comb begin
    go_access = 1'b0;
    case (operation_i)
      OP_VOTE:    go_access = !recovered_q && in_store && (byte_index_i < pkt_len_q);
      OP_RESOLVE: go_access = 1'b1;
      default:    go_access = 1'b0;
    endcase
  end

  assign out_free   = !out_valid_o || !out_stall_i;
  assign commit_rsv = (state_q == S_ACCESS) && (op_q == OP_RESOLVE) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc && go_access) state_d = S_ACCESS;
      end
      S_ACCESS: begin
        if (op_q != OP_RESOLVE || out_free) state_d = S_IDLE;
      end
    endcase
  end

  logic [DW-1:0] rd_data, upd_in, upd_out;
  logic [7:0]    majority, vote_byte;

  // The input is never stalled in the idle state, so a valid request there is accepted.
  always_comb begin
    in_stall_o      = 1'b1;
    mem_req.clear   = 1'b0;
    mem_req.rd_en   = 1'b0;
    mem_req.rd_addr = byte_index_i;
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = idx_q;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        mem_req.clear = in_valid_i && (operation_i == OP_CLEAR);
        mem_req.rd_en = in_valid_i && go_access;
      end
      S_ACCESS: begin
        mem_req.wr_en = (op_q == OP_VOTE);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // The request is held for its memory cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= OP_NOP;
    end else if (in_acc) begin
      op_q <= operation_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      idx_q    <= byte_index_i;
      data_q   <= data_byte_i;
      last_q   <= last_i;
      inr_q    <= in_store;
      forced_q <= forced;
    end
  end

  bvpr_mem #(
    .MAX_BYTES   (MAX_BYTES),
    .COUNTER_BITS(COUNTER_BITS)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mem_req),
    .wr_data_i(upd_out),
    .rd_data_o(rd_data)
  );

  // Positions beyond storage read as zero counters, which resolve to all ones.
  assign upd_in    = inr_q ? rd_data : '0;
  assign vote_byte = forced_q ? 8'h00 : data_q;

  bvpr_update #(
    .COUNTER_BITS(COUNTER_BITS)
  ) u_update (
    .cnt_i      (upd_in),
    .vote_byte_i(vote_byte),
    .cnt_o      (upd_out),
    .majority_o (majority)
  );

  // Check evaluation for a resolve request
  logic [8:0]  p9, len9;
  logic [15:0] crc_n, rx_n;
  status_e     status_n;

  assign p9   = {1'b0, idx_q};
  assign len9 = {1'b0, pkt_len_q};

  always_comb begin
    crc_n    = crc_q;
    rx_n     = rx_q;
    status_n = STAT_BYTE;
    if ((p9 + CHK_BYTES) < len9) begin
      crc_n = crc_feed(crc_q, forced_q ? 8'h00 : majority);
    end else if ((p9 + CHK_BYTES) == len9) begin
      rx_n = {rx_q[15:8], majority};
    end else if ((p9 + 9'd1) == len9) begin
      rx_n = {majority, rx_q[7:0]};
    end
    if (last_q) begin
      if (copy_cnt_q < min_votes_q) status_n = STAT_FEW;
      else if (crc_n == rx_n)       status_n = STAT_MATCH;
      else                          status_n = STAT_FAIL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      copy_cnt_q  <= 8'd0;
      recovered_q <= 1'b0;
      crc_q       <= CRC_INIT;
      rx_q        <= 16'd0;
    end else if (in_acc && (operation_i == OP_CLEAR)) begin
      copy_cnt_q  <= 8'd0;
      recovered_q <= 1'b0;
      crc_q       <= CRC_INIT;
      rx_q        <= 16'd0;
    end else begin
      // A copy counts on its last byte, even when that byte lies beyond the packet.
      if (in_acc && (operation_i == OP_VOTE) && !recovered_q && last_i &&
          (copy_cnt_q != 8'd255)) begin
        copy_cnt_q <= copy_cnt_q + 8'd1;
      end
      if (commit_rsv) begin
        if (last_q) begin
          crc_q <= CRC_INIT;
          rx_q  <= 16'd0;
          if (status_n == STAT_MATCH) recovered_q <= 1'b1;
        end else begin
          crc_q <= crc_n;
          rx_q  <= rx_n;
        end
      end
    end
  end

  // Result register
  logic       out_valid_q;
  logic [7:0] voted_q, copies_q;
  status_e    status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit_rsv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit_rsv) begin
      voted_q  <= majority;
      status_q <= status_n;
      copies_q <= copy_cnt_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign voted_byte_o   = voted_q;
  assign status_o       = status_q;
  assign copies_voted_o = copies_q;

  // A vote request returns to the idle state straight after its write-back in S_ACCESS.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACCESS && op_q == OP_VOTE) |=> (state_q == S_IDLE))
    else $error("vote request stayed in the memory cycle");

  // A result appears only after a resolve request has finished its memory cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> $past(state_q == S_ACCESS && op_q == OP_RESOLVE))
    else $error("result produced without a resolve request");

  // Once recovered, the copy count is frozen until a clear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (recovered_q && !(in_acc && operation_i == OP_CLEAR)) |=> $stable(copy_cnt_q))
    else $error("copy count moved after recovery");

  // A clear request resets the vote bookkeeping.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && operation_i == OP_CLEAR) |=> (copy_cnt_q == 8'd0 && !recovered_q &&
                                             crc_q == CRC_INIT && rx_q == 16'd0))
    else $error("clear request left vote state behind");

endmodule
